>>> rtl/core/slts_pkg.sv
`default_nettype none
package slts_pkg;

  localparam int FLOOR_COUNT = 64;
  localparam int FLOOR_W     = 6;
  localparam int REQ_W       = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 8;

  localparam logic [FLOOR_W-1:0] FLOOR_MAX = FLOOR_W'(FLOOR_COUNT - 1);
  localparam logic [FLOOR_W-1:0] TOP_RESET = 6'd63;

  typedef enum logic [1:0] {
    POL_SCAN  = 2'd0,
    POL_CSCAN = 2'd1,
    POL_LOOK  = 2'd2,
    POL_CLOOK = 2'd3
  } policy_t;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 1'd1;

  typedef struct packed {
    policy_t            policy;
    logic [FLOOR_W-1:0] top_floor;
  } cfg_t;

  typedef struct packed {
    logic [FLOOR_W-1:0] target;
    logic               valid;
    logic               dir_up;
  } decision_t;

  typedef struct packed {
    logic               found;
    logic [FLOOR_W-1:0] idx;
  } enc_t;

  // lowest set bit
  function automatic enc_t find_lowest(input logic [REQ_W-1:0] m);
    enc_t r;
    r.found = |m;
    r.idx   = '0;
    for (int i = REQ_W - 1; i >= 0; i--) begin
      if (m[i]) r.idx = FLOOR_W'(i);
    end
    return r;
  endfunction

  // highest set bit
  function automatic enc_t find_highest(input logic [REQ_W-1:0] m);
    enc_t r;
    r.found = |m;
    r.idx   = '0;
    for (int i = 0; i < REQ_W; i++) begin
      if (m[i]) r.idx = FLOOR_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/slts_decide.sv
`default_nettype none
module slts_decide (
  input  wire logic [slts_pkg::FLOOR_W-1:0] cur,
  input  wire logic [slts_pkg::REQ_W-1:0]   req_raw,
  input  wire slts_pkg::cfg_t               cfg,
  input  wire logic                         dir_up,
  output slts_pkg::decision_t               dec
);

  logic [slts_pkg::FLOOR_W-1:0] top_eff;
  logic [slts_pkg::REQ_W-1:0]   req;
  logic [slts_pkg::REQ_W-1:0]   above;
  logic [slts_pkg::REQ_W-1:0]   below;
  slts_pkg::enc_t               lo_above;
  slts_pkg::enc_t               hi_below;
  slts_pkg::enc_t               lo_req;
  slts_pkg::enc_t               hi_req;
  logic                         circ;
  logic                         dir;

  assign top_eff = (cfg.top_floor > slts_pkg::FLOOR_MAX) ? slts_pkg::FLOOR_MAX
                                                          : cfg.top_floor;

  // drop requests above the served range
  always_comb begin
    for (int i = 0; i < slts_pkg::REQ_W; i++) begin
      req[i]   = req_raw[i] && (i < slts_pkg::FLOOR_COUNT) &&
                 (slts_pkg::FLOOR_W'(i) <= top_eff);
      above[i] = req[i] && (slts_pkg::FLOOR_W'(i) >= cur);
      below[i] = req[i] && (slts_pkg::FLOOR_W'(i) <= cur);
    end
  end

  assign lo_above = slts_pkg::find_lowest(above);
  assign hi_below = slts_pkg::find_highest(below);
  assign lo_req   = slts_pkg::find_lowest(req);
  assign hi_req   = slts_pkg::find_highest(req);

  assign circ = (cfg.policy == slts_pkg::POL_CSCAN) || (cfg.policy == slts_pkg::POL_CLOOK);
  assign dir  = circ ? 1'b1 : dir_up;

  always_comb begin
    dec.target = '0;
    dec.valid  = 1'b1;
    dec.dir_up = dir;
    if (dir) begin
      if (lo_above.found) begin
        dec.target = lo_above.idx;
      end else begin
        case (cfg.policy)
          slts_pkg::POL_SCAN: begin
            if (cur < top_eff) begin
              dec.target = top_eff;
            end else begin
              dec.dir_up = 1'b0;
              dec.target = hi_req.idx;
              dec.valid  = hi_req.found;
            end
          end
          slts_pkg::POL_CSCAN: begin
            dec.target = (cur < top_eff) ? top_eff : '0;
          end
          slts_pkg::POL_LOOK: begin
            dec.dir_up = 1'b0;
            dec.target = hi_req.idx;
            dec.valid  = hi_req.found;
          end
          default: begin
            dec.target = lo_req.idx;
            dec.valid  = lo_req.found;
          end
        endcase
      end
    end else begin
      if (hi_below.found) begin
        dec.target = hi_below.idx;
      end else if ((cfg.policy == slts_pkg::POL_SCAN) && (cur != '0)) begin
        dec.target = '0;
      end else begin
        dec.dir_up = 1'b1;
        dec.target = lo_req.idx;
        dec.valid  = lo_req.found;
      end
    end
    if (!dec.valid) dec.target = '0;
  end

endmodule
`default_nettype wire

>>> rtl/core/scan_look_target_selector.sv
// A request is captured in the input register; its decision then sits in the result register.
// Throughput: one request per cycle unless out_tready stalls; the decision is one pass
//   of four priority encoders over the request bitmap between input and result registers.
// Reset (synchronous, rst_n low): both stages empty, direction up, policy SCAN,
//   top floor 63.
`default_nettype none
module scan_look_target_selector (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request stream
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [5:0] current_floor, [69:6] request_mask, [71:70] zero
  input  wire logic [slts_pkg::IN_DATA_W-1:0]    in_tdata,
  // result stream
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [5:0] target_floor, [6] target_valid, [7] going_up
  output logic [slts_pkg::OUT_DATA_W-1:0]        out_tdata,
  // configuration writes
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [slts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [slts_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // configuration registers
  slts_pkg::cfg_t               cfg_r;

  // input stage
  logic                         in_vld_r;
  logic [slts_pkg::FLOOR_W-1:0] in_cur_r;
  logic [slts_pkg::REQ_W-1:0]   in_req_r;

  // result stage and travel direction
  logic                         out_vld_r;
  slts_pkg::decision_t          out_dec_r;
  logic                         dir_r;

  slts_pkg::decision_t          dec_nxt;
  logic                         advance;

  // Advance the result stage whenever it is empty or being drained; the input
  // stage can then refill in the same cycle, so one request moves per cycle.
  assign advance    = !out_vld_r || out_tready;
  assign in_tready  = !in_vld_r || advance;
  assign cfg_ready  = 1'b1;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_dec_r.dir_up, out_dec_r.valid, out_dec_r.target};

  // Configuration: unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy    <= slts_pkg::POL_SCAN;
      cfg_r.top_floor <= slts_pkg::TOP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        slts_pkg::CFG_POLICY: cfg_r.policy    <= slts_pkg::policy_t'(cfg_wdata[1:0]);
        slts_pkg::CFG_TOP:    cfg_r.top_floor <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register: hold the request until the decision stage takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cur_r <= in_tdata[slts_pkg::FLOOR_W-1:0];
      in_req_r <= in_tdata[slts_pkg::FLOOR_W +: slts_pkg::REQ_W];
    end
  end

  // Decision logic sees the stored direction; it updates only when a
  // request actually moves into the result register.
  slts_decide u_decide (
    .cur     (in_cur_r),
    .req_raw (in_req_r),
    .cfg     (cfg_r),
    .dir_up  (dir_r),
    .dec     (dec_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      dir_r     <= 1'b1;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
      if (in_vld_r) dir_r <= dec_nxt.dir_up;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld_r) begin
      out_dec_r <= dec_nxt;
    end
  end

endmodule
`default_nettype wire
